// ===== rtl/tesq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the touch event scaler queue.
// Used by the channel interfaces and the top level; depends on nothing.
package tesq_pkg;

    // Default sizing, handed to the top level parameters
    localparam int SCREEN_COUNT_DEF = 2;
    localparam int QUEUE_SLOTS_DEF  = 64;

    // Field widths
    localparam int COORD_W  = 16;
    localparam int SCREEN_W = 2;
    localparam int TYPE_W   = 3;
    localparam int RAW_W    = 12;
    localparam int STATUS_W = 3;

    // Raw coordinate range and the marker for "no point recorded"
    localparam logic [RAW_W-1:0] RAW_MAX  = 12'd4092;
    localparam logic [RAW_W-1:0] NO_POINT = 12'd4095;

    // Command codes
    localparam logic CMD_POST = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Touch type codes
    localparam logic [TYPE_W-1:0] TYPE_DOWN = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_MOVE = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_UP   = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_POPPED    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_POSTED    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_OVERWRITE = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 3'd4;

    // One queued event
    typedef struct packed {
        logic [RAW_W-1:0]  x;
        logic [RAW_W-1:0]  y;
        logic [TYPE_W-1:0] ev_type;
    } entry_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP_WAIT,
        ST_SCALE_LOAD,
        ST_SCALE_STEP,
        ST_POST_UPDATE,
        ST_DELIVER
    } state_t;

endpackage

// ===== rtl/tesq_req_if.sv =====
`timescale 1ns / 1ps
// Request channel of the touch event scaler queue: valid/ready plus one item.
// Depends on tesq_pkg for field widths.
interface tesq_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  cmd;
    logic [tesq_pkg::SCREEN_W-1:0]         screen;
    logic signed [tesq_pkg::COORD_W-1:0]   pixel_x;
    logic signed [tesq_pkg::COORD_W-1:0]   pixel_y;
    logic [tesq_pkg::COORD_W-1:0]          window_w;
    logic [tesq_pkg::COORD_W-1:0]          window_h;
    logic [tesq_pkg::TYPE_W-1:0]           event_type;

    modport source (
        output valid, cmd, screen, pixel_x, pixel_y, window_w, window_h, event_type,
        input  ready
    );

    modport sink (
        input  valid, cmd, screen, pixel_x, pixel_y, window_w, window_h, event_type,
        output ready
    );
endinterface

// ===== rtl/tesq_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel of the touch event scaler queue: valid/ready plus one result.
// Depends on tesq_pkg for field widths.
interface tesq_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [tesq_pkg::STATUS_W-1:0]   status;
    logic [tesq_pkg::RAW_W-1:0]      raw_x;
    logic [tesq_pkg::RAW_W-1:0]      raw_y;
    logic [tesq_pkg::TYPE_W-1:0]     out_type;

    modport source (
        output valid, status, raw_x, raw_y, out_type,
        input  ready
    );

    modport sink (
        input  valid, status, raw_x, raw_y, out_type,
        output ready
    );
endinterface

// ===== rtl/touch_event_scaler_queue_top.sv =====
`timescale 1ns / 1ps
// Touch event scaler queue: scales touch points, filters them, rings them per screen.
// Depends on tesq_pkg, tesq_req_if and tesq_rsp_if.
//
// Usage
//   req carries one word per item: a post (cmd 0) scales pixel_x/pixel_y to the
//   0..4092 raw range and queues the event on its screen, a pop (cmd 1) takes
//   the oldest event of the screen. rsp returns exactly one word per item with
//   a status code and, for a successful pop, the event's point and type.
// Sequencing
//   One item at a time. A pop goes through the registered read of the event
//   memory. In a post, each coordinate that is not clamped goes through a
//   shared restoring divider, one quotient bit per cycle after a load step.
//   Rejected items and pops of an empty queue go straight from decode to
//   delivery.
//   The next item is accepted as soon as the result sits in the output register.
// Reset
//   Clears all ring pointers and pressed flags and marks no point recorded.
//   The event memory is not cleared; only written slots are ever popped.
// Stall
//   A result held by a stalled receiver stays in the output register; the
//   block takes one more item and holds its result until the register frees.
module touch_event_scaler_queue_top #(
    parameter int SCREEN_COUNT = tesq_pkg::SCREEN_COUNT_DEF,
    parameter int QUEUE_SLOTS  = tesq_pkg::QUEUE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tesq_req_if.sink    req,
    tesq_rsp_if.source  rsp
);

    localparam int PTR_W  = $clog2(QUEUE_SLOTS);
    localparam int SCR_W  = (SCREEN_COUNT > 1) ? $clog2(SCREEN_COUNT) : 1;
    localparam int DEPTH  = SCREEN_COUNT * QUEUE_SLOTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_SLOTS - 1);
    localparam logic [2:0]       SCR_LIMIT = 3'(SCREEN_COUNT);
    localparam int RAW_W  = tesq_pkg::RAW_W;
    localparam int NUM_W  = 27;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_LAST) ? '0 : PTR_W'(p + 1'b1);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    tesq_pkg::state_t state_reg, state_next;

    logic                               cmd_reg;
    logic [tesq_pkg::SCREEN_W-1:0]      screen_reg;
    logic signed [tesq_pkg::COORD_W-1:0] px_reg, py_reg;
    logic [tesq_pkg::COORD_W-1:0]       ww_reg, wh_reg;
    logic [tesq_pkg::TYPE_W-1:0]        type_reg;

    logic [PTR_W-1:0]  wr_ptr_reg [SCREEN_COUNT];
    logic [PTR_W-1:0]  rd_ptr_reg [SCREEN_COUNT];
    logic [RAW_W-1:0]  prev_x_reg [SCREEN_COUNT];
    logic [RAW_W-1:0]  prev_y_reg [SCREEN_COUNT];
    logic              pressed_reg [SCREEN_COUNT];

    tesq_pkg::entry_t  mem [DEPTH];
    tesq_pkg::entry_t  rd_data_reg;

    // divider
    logic              coord_sel_reg, coord_sel_next;
    logic [3:0]        bit_cnt_reg, bit_cnt_next;
    logic [15:0]       rem_reg, rem_next;
    logic [RAW_W-1:0]  numlo_reg, numlo_next;
    logic [RAW_W-1:0]  quot_reg, quot_next;
    logic [RAW_W-1:0]  rx_reg, ry_reg;

    // pending result and output register
    logic [tesq_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [RAW_W-1:0]              res_x_reg, res_x_next;
    logic [RAW_W-1:0]              res_y_reg, res_y_next;
    logic [tesq_pkg::TYPE_W-1:0]   res_type_reg, res_type_next;

    logic                          out_valid_reg, out_valid_next;
    logic [tesq_pkg::STATUS_W-1:0] out_status_reg;
    logic [RAW_W-1:0]              out_x_reg, out_y_reg;
    logic [tesq_pkg::TYPE_W-1:0]   out_type_reg;

    // ------------------------------------------------------------------
    // Decode of the held item
    // ------------------------------------------------------------------
    logic              accept;
    logic              scr_ok;
    logic [SCR_W-1:0]  scr_idx;
    logic [PTR_W-1:0]  wr_cur, rd_cur, wr_nxt, rd_nxt;
    logic              q_empty, q_full;
    logic              bad_post;
    logic              is_down, is_move, is_up, drop;
    logic [ADDR_W-1:0] base_addr, wr_addr, rd_addr;

    assign accept   = req.valid && req.ready;
    assign scr_ok   = {1'b0, screen_reg} < SCR_LIMIT;
    assign scr_idx  = screen_reg[SCR_W-1:0];
    assign wr_cur   = wr_ptr_reg[scr_idx];
    assign rd_cur   = rd_ptr_reg[scr_idx];
    assign wr_nxt   = ring_next(wr_cur);
    assign rd_nxt   = ring_next(rd_cur);
    assign q_empty  = (rd_cur == wr_cur);
    assign q_full   = (wr_nxt == rd_cur);
    assign bad_post = !scr_ok || (ww_reg == '0) || (wh_reg == '0);

    assign is_down  = (type_reg == tesq_pkg::TYPE_DOWN);
    assign is_move  = (type_reg == tesq_pkg::TYPE_MOVE);
    assign is_up    = (type_reg == tesq_pkg::TYPE_UP);
    assign drop     = is_move && (!pressed_reg[scr_idx] ||
                      ((rx_reg == prev_x_reg[scr_idx]) && (ry_reg == prev_y_reg[scr_idx])));

    assign base_addr = ADDR_W'(scr_idx) * ADDR_W'(QUEUE_SLOTS);
    assign wr_addr   = ADDR_W'(base_addr + ADDR_W'(wr_cur));
    assign rd_addr   = ADDR_W'(base_addr + ADDR_W'(rd_cur));

    // ------------------------------------------------------------------
    // Divider datapath: coordinate * 4092 / size, clamped
    // ------------------------------------------------------------------
    logic signed [tesq_pkg::COORD_W-1:0] coord;
    logic [tesq_pkg::COORD_W-1:0]        size;
    logic                                coord_neg, coord_sat;
    logic [NUM_W-1:0]                    num;
    logic [16:0]                         rem2;
    logic                                q_bit;
    logic [RAW_W-1:0]                    quot_step;

    assign coord     = coord_sel_reg ? py_reg : px_reg;
    assign size      = coord_sel_reg ? wh_reg : ww_reg;
    assign coord_neg = coord[15];
    // quotient reaches 4092 exactly when the coordinate reaches the size
    assign coord_sat = {1'b0, coord[14:0]} >= size;
    assign num       = {coord[14:0], 12'd0} - {10'd0, coord[14:0], 2'd0};
    assign rem2      = {rem_reg, numlo_reg[RAW_W-1]};
    assign q_bit     = rem2 >= {1'b0, size};
    assign quot_step = {quot_reg[RAW_W-2:0], q_bit};

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tesq_pkg::ST_IDLE:
            begin
                if (req.valid)
                    state_next = tesq_pkg::ST_DECODE;
            end
            tesq_pkg::ST_DECODE:
            begin
                if (cmd_reg == tesq_pkg::CMD_POP)
                    state_next = (!scr_ok || q_empty) ? tesq_pkg::ST_DELIVER
                                                      : tesq_pkg::ST_POP_WAIT;
                else
                    state_next = bad_post ? tesq_pkg::ST_DELIVER : tesq_pkg::ST_SCALE_LOAD;
            end
            tesq_pkg::ST_POP_WAIT:
                state_next = tesq_pkg::ST_DELIVER;
            tesq_pkg::ST_SCALE_LOAD:
            begin
                if (coord_neg || coord_sat)
                    state_next = coord_sel_reg ? tesq_pkg::ST_POST_UPDATE
                                               : tesq_pkg::ST_SCALE_LOAD;
                else
                    state_next = tesq_pkg::ST_SCALE_STEP;
            end
            tesq_pkg::ST_SCALE_STEP:
            begin
                if (bit_cnt_reg == '0)
                    state_next = coord_sel_reg ? tesq_pkg::ST_POST_UPDATE
                                               : tesq_pkg::ST_SCALE_LOAD;
            end
            tesq_pkg::ST_POST_UPDATE:
                state_next = tesq_pkg::ST_DELIVER;
            tesq_pkg::ST_DELIVER:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = tesq_pkg::ST_IDLE;
            end
            default:
                state_next = tesq_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs: strobes and values written this cycle
    // ------------------------------------------------------------------
    logic              mem_re, mem_we;
    logic              rd_ptr_we, wr_ptr_we, prev_we, pressed_we;
    logic              res_we, coord_we, out_load;
    logic [RAW_W-1:0]  coord_res;

    always_comb
    begin
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        rd_ptr_we       = 1'b0;
        wr_ptr_we       = 1'b0;
        prev_we         = 1'b0;
        pressed_we      = 1'b0;
        res_we          = 1'b0;
        coord_we        = 1'b0;
        out_load        = 1'b0;
        coord_res       = quot_step;
        coord_sel_next  = coord_sel_reg;
        bit_cnt_next    = bit_cnt_reg;
        rem_next        = rem_reg;
        numlo_next      = numlo_reg;
        quot_next       = quot_reg;
        res_status_next = tesq_pkg::STATUS_EMPTY;
        res_x_next      = '0;
        res_y_next      = '0;
        res_type_next   = '0;
        case (state_reg)
            tesq_pkg::ST_IDLE:
                coord_sel_next = 1'b0;
            tesq_pkg::ST_DECODE:
            begin
                res_we = 1'b1;
                if (cmd_reg == tesq_pkg::CMD_POP)
                begin
                    mem_re          = scr_ok && !q_empty;
                    res_status_next = tesq_pkg::STATUS_EMPTY;
                end
                else
                    res_status_next = tesq_pkg::STATUS_IGNORED;
            end
            tesq_pkg::ST_POP_WAIT:
            begin
                res_we          = 1'b1;
                rd_ptr_we       = 1'b1;
                res_status_next = tesq_pkg::STATUS_POPPED;
                res_x_next      = rd_data_reg.x;
                res_y_next      = rd_data_reg.y;
                res_type_next   = rd_data_reg.ev_type;
            end
            tesq_pkg::ST_SCALE_LOAD:
            begin
                rem_next     = {1'b0, num[NUM_W-1:RAW_W]};
                numlo_next   = num[RAW_W-1:0];
                quot_next    = '0;
                bit_cnt_next = 4'(RAW_W - 1);
                if (coord_neg || coord_sat)
                begin
                    coord_we       = 1'b1;
                    coord_res      = coord_neg ? '0 : tesq_pkg::RAW_MAX;
                    coord_sel_next = 1'b1;
                end
            end
            tesq_pkg::ST_SCALE_STEP:
            begin
                // one restoring step: shift in a bit, subtract if it fits
                rem_next     = q_bit ? 16'(rem2 - {1'b0, size}) : rem2[15:0];
                numlo_next   = {numlo_reg[RAW_W-2:0], 1'b0};
                quot_next    = quot_step;
                bit_cnt_next = bit_cnt_reg - 4'd1;
                if (bit_cnt_reg == '0)
                begin
                    coord_we       = 1'b1;
                    coord_res      = quot_step;
                    coord_sel_next = 1'b1;
                end
            end
            tesq_pkg::ST_POST_UPDATE:
            begin
                res_we     = 1'b1;
                mem_we     = !drop;
                wr_ptr_we  = !drop;
                rd_ptr_we  = !drop && q_full;
                prev_we    = !drop && (is_down || is_move || is_up);
                pressed_we = is_down || is_up;
                if (drop)
                    res_status_next = tesq_pkg::STATUS_IGNORED;
                else if (q_full)
                    res_status_next = tesq_pkg::STATUS_OVERWRITE;
                else
                    res_status_next = tesq_pkg::STATUS_POSTED;
            end
            tesq_pkg::ST_DELIVER:
                out_load = !out_valid_reg || rsp.ready;
            default:
                coord_sel_next = 1'b0;
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tesq_pkg::ST_IDLE;
            coord_sel_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            coord_sel_reg <= coord_sel_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Per-screen ring pointers and press state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SCREEN_COUNT; i++)
            begin
                wr_ptr_reg[i]  <= '0;
                rd_ptr_reg[i]  <= '0;
                prev_x_reg[i]  <= tesq_pkg::NO_POINT;
                prev_y_reg[i]  <= tesq_pkg::NO_POINT;
                pressed_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (wr_ptr_we)
                wr_ptr_reg[scr_idx] <= wr_nxt;
            if (rd_ptr_we)
                rd_ptr_reg[scr_idx] <= rd_nxt;
            if (prev_we)
            begin
                prev_x_reg[scr_idx] <= rx_reg;
                prev_y_reg[scr_idx] <= ry_reg;
            end
            if (pressed_we)
                pressed_reg[scr_idx] <= is_down;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    // hold the accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= req.cmd;
            screen_reg <= req.screen;
            px_reg     <= req.pixel_x;
            py_reg     <= req.pixel_y;
            ww_reg     <= req.window_w;
            wh_reg     <= req.window_h;
            type_reg   <= req.event_type;
        end
    end

    // advance the divider and capture each finished coordinate
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        numlo_reg <= numlo_next;
        quot_reg  <= quot_next;
        if (coord_we)
        begin
            if (coord_sel_reg)
                ry_reg <= coord_res;
            else
                rx_reg <= coord_res;
        end
    end

    // hold the pending result, then move it to the output register
    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_status_reg <= res_status_next;
            res_x_reg      <= res_x_next;
            res_y_reg      <= res_y_next;
            res_type_reg   <= res_type_next;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_x_reg      <= res_x_reg;
            out_y_reg      <= res_y_reg;
            out_type_reg   <= res_type_reg;
        end
    end

    // ------------------------------------------------------------------
    // Event memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= '{x: rx_reg, y: ry_reg, ev_type: type_reg};
        if (mem_re)
            rd_data_reg <= mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Channel outputs
    // ------------------------------------------------------------------
    assign req.ready    = (state_reg == tesq_pkg::ST_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.raw_x    = out_x_reg;
    assign rsp.raw_y    = out_y_reg;
    assign rsp.out_type = out_type_reg;

endmodule
